// ===== hw/rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps
package wsd_pkg;

  // Parse phase of the byte stream
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_DATA   = 1'b1
  } kind_e;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Extended length and key byte counters (bytes still to come after this one)
  localparam logic [2:0] EXT16_LEFT = 3'd1;
  localparam logic [2:0] EXT64_LEFT = 3'd7;
  localparam logic [2:0] KEY_LEFT   = 3'd3;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LEN_W   = 64;
  localparam int unsigned ODATA_W = 88;   // 81 field bits padded to whole bytes
  localparam int unsigned PADDR_W = 3;

  localparam logic [PADDR_W-1:0] ADDR_UNMASK = 3'd0;

  typedef struct packed {
    kind_e             kind;
    logic              fin;
    logic [2:0]        rsv;
    logic [3:0]        opcode;
    logic              masked;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
    logic              last;
  } res_t;

endpackage

// ===== hw/rtl/wsd_parser.sv =====
`timescale 1ns / 1ps
module wsd_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        beat_i,
  input  logic [wsd_pkg::DATA_W-1:0]  byte_i,
  input  logic                        unmask_en_i,
  output logic                        res_valid_o,
  output wsd_pkg::res_t               res_o
);
  import wsd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               fin_q, fin_d;
  logic [2:0]         rsv_q, rsv_d;
  logic [3:0]         opc_q, opc_d;
  logic               masked_q, masked_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LEN_W-1:0]   rem_q, rem_d;
  logic [31:0]        key_q, key_d;
  logic [1:0]         pos_q, pos_d;

  logic               len_done;   // length now known
  logic               hdr_done;   // header complete this beat
  logic               data_beat;
  logic               data_last;
  logic [LEN_W-1:0]   rem_dec;
  logic [DATA_W-1:0]  key_byte;
  logic [DATA_W-1:0]  data_out;

  assign rem_dec   = rem_q - LEN_W'(1);
  assign data_last = (rem_dec == '0);

  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Field and counter updates
  always_comb begin
    cnt_d     = cnt_q;
    fin_d     = fin_q;
    rsv_d     = rsv_q;
    opc_d     = opc_q;
    masked_d  = masked_q;
    len_d     = len_q;
    rem_d     = rem_q;
    key_d     = key_q;
    pos_d     = pos_q;
    len_done  = 1'b0;
    hdr_done  = 1'b0;
    data_beat = 1'b0;
    data_out  = byte_i;
    if (beat_i) begin
      case (phase_q)
        PH_HDR1: begin
          masked_d = byte_i[7];
          len_d    = '0;
          if (byte_i[6:0] == LEN_CODE_EXT16) begin
            cnt_d = EXT16_LEFT;
          end else if (byte_i[6:0] == LEN_CODE_EXT64) begin
            cnt_d = EXT64_LEFT;
          end else begin
            len_d    = LEN_W'(byte_i[6:0]);
            len_done = 1'b1;
          end
        end
        PH_EXT: begin
          len_d = {len_q[LEN_W-DATA_W-1:0], byte_i};
          if (cnt_q == '0) begin
            len_done = 1'b1;
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], byte_i};
          if (cnt_q == '0) begin
            hdr_done = 1'b1;
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
        PH_DATA: begin
          data_beat = 1'b1;
          if (unmask_en_i && masked_q) begin
            data_out = byte_i ^ key_byte;
          end
          pos_d = pos_q + 2'd1;
          rem_d = rem_dec;
        end
        default: begin
          fin_d = byte_i[7];
          rsv_d = byte_i[6:4];
          opc_d = byte_i[3:0];
        end
      endcase
      // Length known: either go collect the key or the header is done
      if (len_done) begin
        if (masked_d) begin
          cnt_d = KEY_LEFT;
          key_d = '0;
        end else begin
          hdr_done = 1'b1;
        end
      end
      if (hdr_done) begin
        rem_d = len_d;
        pos_d = '0;
        cnt_d = '0;
      end
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (beat_i) begin
      case (phase_q)
        PH_HDR1: phase_d = PH_EXT;
        PH_EXT:  phase_d = PH_EXT;
        PH_KEY:  phase_d = PH_KEY;
        PH_DATA: phase_d = data_last ? PH_HDR0 : PH_DATA;
        default: phase_d = PH_HDR1;
      endcase
      if (len_done && masked_d) begin
        phase_d = PH_KEY;
      end
      if (hdr_done) begin
        phase_d = (len_d == '0) ? PH_HDR0 : PH_DATA;
      end
    end
  end

  // Result
  always_comb begin
    res_valid_o  = hdr_done || data_beat;
    res_o.kind   = data_beat ? KIND_DATA : KIND_HEADER;
    res_o.fin    = fin_d;
    res_o.rsv    = rsv_d;
    res_o.opcode = opc_d;
    res_o.masked = masked_d;
    res_o.length = len_d;
    res_o.data   = data_beat ? data_out : '0;
    res_o.last   = data_beat ? data_last : (len_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      rsv_q    <= '0;
      opc_q    <= '0;
      masked_q <= 1'b0;
      len_q    <= '0;
      rem_q    <= '0;
      key_q    <= '0;
      pos_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      fin_q    <= fin_d;
      rsv_q    <= rsv_d;
      opc_q    <= opc_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/wsd_skid.sv =====
`timescale 1ns / 1ps
module wsd_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wsd_pkg::res_t  data_i,
  output logic           space_o,
  output logic           valid_o,
  input  logic           ready_i,
  output wsd_pkg::res_t  data_o
);
  import wsd_pkg::*;

  // Two-entry result buffer; head is entry 0
  logic [1:0] cnt_q, cnt_d;
  res_t       e0_q, e0_d;
  res_t       e1_q, e1_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign data_o  = e0_q;

  always_comb begin
    cnt_d = cnt_q;
    e0_d  = e0_q;
    e1_d  = e1_q;
    case (cnt_q)
      2'd0: begin
        if (push_i) begin
          e0_d  = data_i;
          cnt_d = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          e0_d = data_i;
        end else if (push_i) begin
          e1_d  = data_i;
          cnt_d = 2'd2;
        end else if (pop) begin
          cnt_d = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          e0_d  = e1_q;
          cnt_d = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// WebSocket frame deframer. Raw stream bytes enter one per beat on the s_axis
// side; the block walks each frame header (flags/opcode byte, mask bit and
// 7-bit length, optional 16- or 64-bit big-endian extended length, optional
// 4-byte mask key) and emits nothing until the header is complete. It then
// emits one header beat (tuser = 0) followed by one beat per payload byte
// (tuser = 1), unmasked with the key when unmask_enable is set and the frame
// is masked. tlast marks the final payload byte, or the header beat of an
// empty frame. Every result beat repeats the frame's header fields. One input
// byte is taken per clock while the output buffer has room; results pass
// through a two-entry output buffer, so input keeps flowing while one result
// waits and stalls only when both entries are full. Each result is registered
// in that buffer before it appears on m_axis.
// Register map (APB, pready always high): 0x0 unmask_enable (bit 0, reset 1).
module websocket_frame_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] in_byte
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] fin_flag, [3:1] reserved_bits, [7:4] frame_opcode, [8] mask_flag,
  // [72:9] payload_length, [80:73] data_byte, [87:81] zero
  output logic [wsd_pkg::ODATA_W-1:0]  m_axis_tdata,
  output logic                         m_axis_tuser,   // [0] kind
  output logic                         m_axis_tlast,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import wsd_pkg::*;

  logic unmask_q, unmask_d;
  logic in_beat;
  logic space;
  logic res_valid;
  res_t res;
  res_t head;

  // Config register
  assign pready = 1'b1;

  always_comb begin
    unmask_d = unmask_q;
    if (psel && penable && pwrite && pready && (paddr == ADDR_UNMASK)) begin
      unmask_d = pwdata[0];
    end
  end

  assign prdata = (paddr == ADDR_UNMASK) ? {31'd0, unmask_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unmask_q <= 1'b1;
    end else begin
      unmask_q <= unmask_d;
    end
  end

  // Byte is taken whenever the output buffer has room for its result
  assign s_axis_tready = space;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (in_beat),
    .byte_i      (s_axis_tdata),
    .unmask_en_i (unmask_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  assign m_axis_tdata = {7'd0, head.data, head.length, head.masked,
                         head.opcode, head.rsv, head.fin};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Frame deframer bench: stream bytes in, header and payload beats out.
// A parser mirror runs on every accepted input beat and queues the beats the
// block must produce; each output beat is checked against the oldest one.
module tb;
  import wsd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no beat, APB or stream
  localparam int unsigned MAX_SHOWN   = 10;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [ODATA_W-1:0]    m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // Parser mirror: frame header as seen so far, key, position in payload
  phase_e                parse_ph  = PH_HDR0;
  logic [2:0]            cnt_left  = '0;   // extended-length / key bytes still to come
  logic                  hdr_fin   = 1'b0;
  logic [2:0]            hdr_rsv   = '0;
  logic [3:0]            hdr_opc   = '0;
  logic                  hdr_mask  = 1'b0;
  logic [LEN_W-1:0]      frm_len   = '0;
  logic [LEN_W-1:0]      remain    = '0;
  logic [31:0]           key       = '0;   // first key byte in [31:24]
  logic [1:0]            key_pos   = '0;
  logic                  unmask_en = 1'b1;

  res_t                  frame_results_due[$];
  res_t                  seen;
  res_t                  want;

  int unsigned           n_bad     = 0;
  int unsigned           n_sent    = 0;
  int unsigned           quiet     = 0;
  int unsigned           hold_len  = 0;    // one-off long receiver hold-off
  bit                    src_idle  = 1'b1;
  bit                    sink_idle = 1'b1;

  websocket_frame_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Parser mirror
  // ---------------------------------------------------------------------------

  function automatic void queue_result(kind_e k, logic [7:0] d, logic l);
    res_t r;
    r.kind   = k;
    r.fin    = hdr_fin;
    r.rsv    = hdr_rsv;
    r.opcode = hdr_opc;
    r.masked = hdr_mask;
    r.length = frm_len;
    r.data   = d;
    r.last   = l;
    frame_results_due.push_back(r);
  endfunction

  // Header complete: one header beat, then payload or back to the next frame
  function automatic void header_done();
    remain   = frm_len;
    key_pos  = '0;
    cnt_left = '0;
    parse_ph = (frm_len == '0) ? PH_HDR0 : PH_DATA;
    queue_result(KIND_HEADER, 8'h00, frm_len == '0);
  endfunction

  // Length known: a masked frame still owes its 4 key bytes
  function automatic void length_done();
    if (hdr_mask) begin
      parse_ph = PH_KEY;
      cnt_left = KEY_LEFT;
      key      = '0;
    end else begin
      header_done();
    end
  endfunction

  function automatic void parse_stream_byte(logic [7:0] b);
    logic [7:0] d;
    case (parse_ph)
      PH_HDR1: begin
        hdr_mask = b[7];
        frm_len  = '0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          parse_ph = PH_EXT;
          cnt_left = EXT16_LEFT;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          parse_ph = PH_EXT;
          cnt_left = EXT64_LEFT;
        end else begin
          frm_len = {57'd0, b[6:0]};
          length_done();
        end
      end
      PH_EXT: begin
        // big-endian, taken as is: no minimal-encoding or top-bit check
        frm_len = {frm_len[LEN_W-9:0], b};
        if (cnt_left == '0) length_done();
        else cnt_left = cnt_left - 3'd1;
      end
      PH_KEY: begin
        key = {key[23:0], b};
        if (cnt_left == '0) header_done();
        else cnt_left = cnt_left - 3'd1;
      end
      PH_DATA: begin
        d = b;
        // enable looked at per payload beat, so a mid-frame write takes effect at once
        if (unmask_en && hdr_mask) d = d ^ key[8*(3-key_pos) +: 8];
        key_pos = key_pos + 2'd1;
        remain  = remain - 64'd1;
        if (remain == '0) parse_ph = PH_HDR0;
        queue_result(KIND_DATA, d, remain == '0);
      end
      default: begin
        hdr_fin  = b[7];
        hdr_rsv  = b[6:4];
        hdr_opc  = b[3:0];
        parse_ph = PH_HDR1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic string fmt_result(res_t r);
    return $sformatf("kind %0d fin %0d rsv %0d op %h mask %0d len %h data %h last %0d",
                     r.kind, r.fin, r.rsv, r.opcode, r.masked, r.length, r.data, r.last);
  endfunction

  function automatic void flag_mismatch(string msg);
    if (n_bad < MAX_SHOWN) $display("mismatch @%0t: %s", $realtime, msg);
    n_bad++;
  endfunction

  // Mirror first, then compare: the new expectation goes to the back, so this
  // order holds for any output latency.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) parse_stream_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind   = kind_e'(m_axis_tuser);
        seen.fin    = m_axis_tdata[0];
        seen.rsv    = m_axis_tdata[3:1];
        seen.opcode = m_axis_tdata[7:4];
        seen.masked = m_axis_tdata[8];
        seen.length = m_axis_tdata[72:9];
        seen.data   = m_axis_tdata[80:73];
        seen.last   = m_axis_tlast;
        if (m_axis_tdata[ODATA_W-1:81] !== '0)
          flag_mismatch($sformatf("tdata pad bits %h", m_axis_tdata[ODATA_W-1:81]));
        if (frame_results_due.size() == 0) begin
          flag_mismatch($sformatf("beat with nothing pending: %s", fmt_result(seen)));
        end else begin
          want = frame_results_due.pop_front();
          if (seen !== want)
            flag_mismatch($sformatf("exp %s | got %s", fmt_result(want), fmt_result(seen)));
        end
      end
    end
  end

  // Watchdog: any accepted beat or APB access counts as progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d beats pending",
               quiet, frame_results_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold-off when asked
  // ---------------------------------------------------------------------------

  initial begin : sink
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
        m_axis_tready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Every task is entered and left just after a falling edge, so
  // the mirror has seen all earlier beats by the time a task looks at it.
  // ---------------------------------------------------------------------------

  task automatic put_byte(input logic [7:0] b);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Random byte, except high extended-length bytes are zeroed so a garbled
  // stream never announces a payload too long to finish.
  function automatic logic [7:0] tame_noise(logic [7:0] b);
    if (parse_ph == PH_EXT && cnt_left != '0) return 8'h00;
    return b;
  endfunction

  task automatic finish_open_frame();
    while (parse_ph != PH_HDR0) put_byte(tame_noise(8'($urandom_range(0, 255))));
  endtask

  // form: 0 short length, 1 16-bit extended, 2 64-bit extended
  task automatic send_header(input logic [63:0] len, input int form, input bit msk);
    put_byte(8'($urandom_range(0, 255)));
    if (form == 0) begin
      put_byte({msk, len[6:0]});
    end else if (form == 1) begin
      put_byte({msk, LEN_CODE_EXT16});
      put_byte(len[15:8]);
      put_byte(len[7:0]);
    end else begin
      put_byte({msk, LEN_CODE_EXT64});
      for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
    end
    if (msk) repeat (4) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame();
    logic [63:0] len;
    int          form;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)      len = 64'($urandom_range(0, 8));
    else if (pick < 90) len = 64'($urandom_range(9, 60));
    else if (pick < 96) len = 64'($urandom_range(100, 125));
    else                len = 64'($urandom_range(126, 300));
    // small lengths also go out in the longer encodings (non-minimal)
    if (len > 125)                       form = $urandom_range(1, 2);
    else if ($urandom_range(0, 2) == 0)  form = $urandom_range(1, 2);
    else                                 form = 0;
    send_header(len, form, 1'($urandom_range(0, 1)));
    send_payload(32'(len));
  endtask

  // Drop valid and wait until every pending beat is out.
  task automatic settle_stream();
    s_axis_tvalid <= 1'b0;
    while (frame_results_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write, then read back unmask_enable. Only call with the stream settled.
  task automatic write_unmask(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_UNMASK) unmask_en = value[0];  // other indexes are ignored
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_UNMASK;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'd0, unmask_en})
      flag_mismatch($sformatf("unmask_enable readback exp %0d got %h", unmask_en, prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked frames: empty control frame, masked short frame with extreme
  // key bytes, 16-bit extended length of zero, and a 64-bit non-minimal
  // length with every reserved bit and the top opcode set.
  task automatic test_directed_frames();
    logic [7:0] seq[$];
    seq = '{8'h89, 8'h00,
            8'h81, 8'h83, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h3C,
            8'h02, 8'h7E, 8'h00, 8'h00,
            8'h7F, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
            8'hFF};
    foreach (seq[i]) put_byte(seq[i]);
    settle_stream();
  endtask

  // unmask_enable: off (only bit 0 counts), write to an unused index, and
  // toggled in the middle of a masked payload.
  task automatic test_unmask_register();
    write_unmask(ADDR_UNMASK, 32'hFFFF_FFFE);
    send_header(64'd5, 0, 1'b1);
    send_payload(5);
    settle_stream();
    write_unmask(3'd4, 32'h0000_0001);
    send_header(64'd4, 1, 1'b1);
    send_payload(4);
    settle_stream();
    write_unmask(ADDR_UNMASK, 32'h0000_0001);
    send_header(64'd8, 0, 1'b1);
    send_payload(4);
    settle_stream();
    write_unmask(ADDR_UNMASK, 32'h0000_0000);
    send_payload(4);
    settle_stream();
    write_unmask(ADDR_UNMASK, 32'hFFFF_FFFF);
  endtask

  // Long receiver hold-off while the sender keeps going: the output buffer
  // fills and s_axis_tready has to drop.
  task automatic test_backpressure();
    src_idle = 1'b0;
    hold_len = 300;
    send_header(64'd120, 0, 1'b1);
    send_payload(120);
    settle_stream();
    src_idle = 1'b1;
  endtask

  // Mostly well-formed frames; some cut short and some raw noise. Each chunk
  // ends with a register write, sometimes in the middle of a payload.
  task automatic test_random_stream();
    int unsigned chunk_end;
    int unsigned len;
    int          pick;
    while (n_sent < 1500) begin
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      finish_open_frame();
      chunk_end = n_sent + $urandom_range(80, 200);
      while (n_sent < chunk_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_random_frame();
        end else if (pick < 90) begin
          // frame cut off, noise lands in its payload
          len = $urandom_range(1, 40);
          send_header(64'(len), $urandom_range(0, 2), 1'($urandom_range(0, 1)));
          send_payload($urandom_range(0, len - 1));
          repeat ($urandom_range(1, 12)) put_byte(tame_noise(8'($urandom_range(0, 255))));
          finish_open_frame();
        end else begin
          repeat ($urandom_range(1, 12)) put_byte(tame_noise(8'($urandom_range(0, 255))));
          finish_open_frame();
        end
      end
      if ($urandom_range(0, 1) == 0) begin
        len = $urandom_range(2, 20);
        send_header(64'(len), $urandom_range(0, 2), 1'b1);
        send_payload($urandom_range(1, len - 1));
      end
      settle_stream();
      write_unmask(($urandom_range(0, 3) == 0) ? 3'd4 : ADDR_UNMASK, $urandom);
    end
    finish_open_frame();
  endtask

  // Back-to-back beats on both sides, then a masked frame whose 64-bit length
  // has every bit set; the run stops partway into its payload.
  task automatic test_final_burst();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    while (n_sent < 1800) send_random_frame();
    put_byte(8'h82);
    put_byte({1'b1, LEN_CODE_EXT64});
    repeat (8) put_byte(8'hFF);
    repeat (4) put_byte(8'($urandom_range(0, 255)));
    send_payload(40);
  endtask

  initial begin : main
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_frames();
    test_unmask_register();
    test_backpressure();
    test_random_stream();
    test_final_burst();

    settle_stream();
    repeat (10) @(posedge clk_i);
    if (n_bad == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_parser.sv
hw/rtl/wsd_skid.sv
hw/rtl/websocket_frame_deframer.sv
tb/tb.sv
